FILE: design/framed_packet_receiver_queue_core_defines.svh
// Assertion helpers for the framed packet receiver queue.
`ifndef FRAMED_PACKET_RECEIVER_QUEUE_CORE_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define FPRQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define FPRQ_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`else
`define FPRQ_ASSERT(lbl, clk, rstn, prop, msg)
`define FPRQ_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg)
`endif

`endif

FILE: design/fprq_pkg.sv
package fprq_pkg;

    // default sizing
    localparam int QUEUE_SLOTS_DEF = 8;
    localparam int MAX_LENGTH_DEF  = 128;

    // front queue
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    // configuration
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 8'd1;
    localparam logic [7:0] HEADER_RESET  = 8'd204;
    localparam logic [7:0] TRAILER_RESET = 8'd185;

    // command codes on the input field
    localparam logic [1:0] CMD_RX   = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_POP  = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    typedef enum logic [1:0] {
        OP_RX,
        OP_READ,
        OP_POP,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEN,
        PH_ID,
        PH_PAYLOAD,
        PH_TAIL,
        PH_CKSUM
    } t_phase;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_ACCEPT    = 3'd1,
        ST_DROP      = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_TAIL  = 3'd4,
        ST_BAD_CKSUM = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } t_fprq_in;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_data;
        logic [7:0] head_id;
        logic [7:0] head_length;
        logic [2:0] queue_count;
        logic       queue_full;
    } t_fprq_out;

    // classified work item, front to back
    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } t_fprq_op;

endpackage

FILE: design/fprq_front.sv
module fprq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fprq_pkg::t_fprq_in  i_in,
    output logic                o_op_valid,
    input  logic                i_op_ready,
    output fprq_pkg::t_fprq_op  o_op
);
    import fprq_pkg::*;

    t_fprq_op             r_q [FQ_DEPTH];
    logic [FQ_PW-1:0]     r_wr;
    logic [FQ_PW-1:0]     r_rd;
    logic [FQ_CW-1:0]     r_cnt;
    t_fprq_op             w_entry;
    logic                 w_push;
    logic                 w_pop;

    // decode command into an operation
    always_comb begin
        w_entry.rx_byte    = i_in.rx_byte;
        w_entry.read_index = i_in.read_index;
        unique case (i_in.cmd)
            CMD_RX:   w_entry.op = OP_RX;
            CMD_READ: w_entry.op = OP_READ;
            CMD_POP:  w_entry.op = OP_POP;
            CMD_NOP:  w_entry.op = OP_NOP;
        endcase
    end

    assign o_in_ready = (r_cnt != FQ_CW'(FQ_DEPTH));
    assign o_op_valid = (r_cnt != '0);
    assign o_op       = r_q[r_rd];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_op_ready && o_op_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_entry;
        end
    end

endmodule

FILE: design/fprq_back.sv
module fprq_back #(
    parameter int QUEUE_SLOTS = fprq_pkg::QUEUE_SLOTS_DEF,
    parameter int MAX_LENGTH  = fprq_pkg::MAX_LENGTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_op_valid,
    output logic                              o_op_ready,
    input  fprq_pkg::t_fprq_op                i_op,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output fprq_pkg::t_fprq_out               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fprq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);
    import fprq_pkg::*;

    localparam int PW    = $clog2(QUEUE_SLOTS);
    localparam int CW    = $clog2(MAX_LENGTH);
    localparam int AW    = PW + CW;
    localparam int DEPTH = QUEUE_SLOTS * (2 ** CW);

    function automatic logic [7:0] bsd_add(input logic [7:0] sum, input logic [7:0] b);
        return {sum[0], sum[7:1]} + b;
    endfunction

    // stores
    logic [7:0]    r_pay_mem [DEPTH];
    logic [7:0]    r_id_mem  [QUEUE_SLOTS];
    logic [7:0]    r_len_mem [QUEUE_SLOTS];
    logic [7:0]    r_pay_q;
    logic [7:0]    r_id_q;
    logic [7:0]    r_len_q;

    // parser and ring state
    t_phase        r_phase, n_phase;
    logic [7:0]    r_cksum, n_cksum;
    logic [7:0]    r_flen, n_flen;
    logic [7:0]    r_fid, n_fid;
    logic [CW-1:0] r_pcnt, n_pcnt;
    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_count, n_count;
    logic [7:0]    r_hdr;
    logic [7:0]    r_trl;

    // result register
    logic          r_out_valid;
    t_status       r_status;
    logic          r_rd_ok;
    logic [PW-1:0] r_cnt_q;

    logic          w_fire;
    logic [7:0]    w_byte;
    logic [7:0]    w_cksum_add;
    logic          w_len_bad;
    logic          w_pay_last;
    logic          w_empty;
    logic          w_full;
    logic [PW-1:0] w_rp_inc;
    logic [PW-1:0] w_wp_inc;
    logic          w_idx_ok;
    t_status       w_status;
    logic          w_rd_ok;
    logic          w_pay_we;
    logic          w_slot_we;
    logic [AW-1:0] w_pay_waddr;
    logic [AW-1:0] w_pay_raddr;

    assign o_cfg_ready = 1'b1;
    assign o_op_ready  = !r_out_valid || i_out_ready;
    assign w_fire      = i_op_valid && o_op_ready;
    assign w_byte      = i_op.rx_byte;
    assign w_cksum_add = bsd_add(r_cksum, w_byte);
    assign w_len_bad   = (w_byte == 8'd0) || ({1'b0, w_byte} > 9'(MAX_LENGTH));
    assign w_pay_last  = (9'(r_pcnt) + 9'd2) >= {1'b0, r_flen};
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == PW'(QUEUE_SLOTS - 1));
    assign w_rp_inc    = (r_rp == PW'(QUEUE_SLOTS - 1)) ? '0 : r_rp + 1'b1;
    assign w_wp_inc    = (r_wp == PW'(QUEUE_SLOTS - 1)) ? '0 : r_wp + 1'b1;
    // r_len_q holds the head slot's length whenever the ring is not empty
    assign w_idx_ok    = ((9'(i_op.read_index) + 9'd1) < {1'b0, r_len_q})
                      && (9'(i_op.read_index) < 9'(MAX_LENGTH));
    assign w_pay_waddr = {r_wp, r_pcnt};
    assign w_pay_raddr = {r_rp, CW'(i_op.read_index)};

    // parse phase transitions
    always_comb begin
        n_phase = r_phase;
        if (w_fire && (i_op.op == OP_RX)) begin
            unique case (r_phase)
                PH_IDLE:    n_phase = (w_byte == r_hdr) ? PH_LEN : PH_IDLE;
                PH_LEN:     n_phase = w_len_bad ? PH_IDLE : PH_ID;
                PH_ID:      n_phase = (r_flen > 8'd1) ? PH_PAYLOAD : PH_TAIL;
                PH_PAYLOAD: n_phase = w_pay_last ? PH_TAIL : PH_PAYLOAD;
                PH_TAIL:    n_phase = (w_byte == r_trl) ? PH_CKSUM : PH_IDLE;
                PH_CKSUM:   n_phase = PH_IDLE;
                default:    n_phase = PH_IDLE;
            endcase
        end
    end

    // datapath updates and status
    always_comb begin
        n_cksum   = r_cksum;
        n_flen    = r_flen;
        n_fid     = r_fid;
        n_pcnt    = r_pcnt;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_count   = r_count;
        w_status  = ST_NONE;
        w_rd_ok   = 1'b0;
        w_pay_we  = 1'b0;
        w_slot_we = 1'b0;
        if (w_fire) begin
            unique case (i_op.op)
                OP_RX: begin
                    unique case (r_phase)
                        PH_IDLE: begin
                            if (w_byte == r_hdr) begin
                                n_cksum = '0;
                                n_pcnt  = '0;
                                n_flen  = '0;
                                n_fid   = '0;
                            end
                        end
                        PH_LEN: begin
                            if (w_len_bad) begin
                                w_status = ST_BAD_LEN;
                            end else begin
                                n_flen = w_byte;
                            end
                        end
                        PH_ID: begin
                            n_fid   = w_byte;
                            n_cksum = w_cksum_add;
                            n_pcnt  = '0;
                        end
                        PH_PAYLOAD: begin
                            w_pay_we = 1'b1;
                            n_cksum  = w_cksum_add;
                            n_pcnt   = w_pay_last ? '0 : r_pcnt + 1'b1;
                        end
                        PH_TAIL: begin
                            if (w_byte != r_trl) begin
                                w_status = ST_BAD_TAIL;
                            end
                        end
                        PH_CKSUM: begin
                            if (w_byte != r_cksum) begin
                                w_status = ST_BAD_CKSUM;
                            end else if (w_full) begin
                                w_status = ST_DROP;
                            end else begin
                                w_slot_we = 1'b1;
                                n_wp      = w_wp_inc;
                                n_count   = r_count + 1'b1;
                                w_status  = ST_ACCEPT;
                            end
                            n_cksum = '0;
                        end
                        default: begin
                        end
                    endcase
                end
                OP_READ: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_rd_ok = w_idx_ok;
                    end
                end
                OP_POP: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        n_rp    = w_rp_inc;
                        n_count = r_count - 1'b1;
                    end
                end
                OP_NOP: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cksum     <= '0;
            r_flen      <= '0;
            r_fid       <= '0;
            r_pcnt      <= '0;
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_hdr       <= HEADER_RESET;
            r_trl       <= TRAILER_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cksum <= n_cksum;
            r_flen  <= n_flen;
            r_fid   <= n_fid;
            r_pcnt  <= n_pcnt;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_count <= n_count;
            if (i_cfg_valid && (i_cfg_index == CFG_HEADER)) begin
                r_hdr <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_TRAILER)) begin
                r_trl <= i_cfg_data;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result fields, captured with the memory read data
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= w_status;
            r_rd_ok  <= w_rd_ok;
            r_cnt_q  <= n_count;
        end
    end

    // payload store; write and read never fall in the same beat
    always_ff @(posedge i_clk) begin
        if (w_pay_we) begin
            r_pay_mem[w_pay_waddr] <= w_byte;
        end
        if (w_fire && w_rd_ok) begin
            r_pay_q <= r_pay_mem[w_pay_raddr];
        end
    end

    // slot id/length store, read at the head after the step, write-first
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_id_mem[r_wp]  <= r_fid;
            r_len_mem[r_wp] <= r_flen;
        end
        if (w_fire) begin
            if (w_slot_we && (r_wp == n_rp)) begin
                r_id_q  <= r_fid;
                r_len_q <= r_flen;
            end else begin
                r_id_q  <= r_id_mem[n_rp];
                r_len_q <= r_len_mem[n_rp];
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.read_data   = r_rd_ok ? r_pay_q : 8'd0;
    assign o_out.head_id     = (r_cnt_q != '0) ? r_id_q : 8'd0;
    assign o_out.head_length = (r_cnt_q != '0) ? r_len_q : 8'd0;
    assign o_out.queue_count = 3'(r_cnt_q);
    assign o_out.queue_full  = (r_cnt_q == PW'(QUEUE_SLOTS - 1));

endmodule

FILE: design/framed_packet_receiver_queue_core.sv
// Channel   Direction  Handshake                   Beat payload
// in        input      i_in_valid / o_in_ready     t_fprq_in  {cmd, rx_byte, read_index}
// out       output     o_out_valid / i_out_ready   t_fprq_out {status .. queue_full}
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One beat in, one beat out; sustained rate one beat per cycle while the output
// is not stalled. An accepted input passes through the front queue, then the
// executing stage and its registered memory read, before the result is valid.
// Reset (i_rst_n low at a clock edge) empties the ring and idles the parser;
// payload and slot stores need no clearing.
// A stalled output holds the back; the two-entry front queue then fills
// and drops o_in_ready. o_cfg_ready is always high.

`include "framed_packet_receiver_queue_core_defines.svh"

module framed_packet_receiver_queue_core #(
    parameter int QUEUE_SLOTS = fprq_pkg::QUEUE_SLOTS_DEF,
    parameter int MAX_LENGTH  = fprq_pkg::MAX_LENGTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  fprq_pkg::t_fprq_in                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output fprq_pkg::t_fprq_out               o_out,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fprq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);
    import fprq_pkg::*;

    // front to back work beat
    logic     w_op_valid;
    logic     w_op_ready;
    t_fprq_op w_op;

    // front: accepts and decodes commands into a short queue
    fprq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_op_valid (w_op_valid),
        .i_op_ready (w_op_ready),
        .o_op       (w_op)
    );

    // back: frame parser, packet ring, stores and result register
    fprq_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .MAX_LENGTH  (MAX_LENGTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (w_op_valid),
        .o_op_ready  (w_op_ready),
        .i_op        (w_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // a full front queue must be offering work to the back
    `FPRQ_ASSERT_IMPL(a_full_front_offers, i_clk, i_rst_n, !o_in_ready, w_op_valid, "front full but idle")
    // empty status reports an empty ring with cleared head fields
    `FPRQ_ASSERT_IMPL(a_empty_fields, i_clk, i_rst_n, o_out_valid && (o_out.status == ST_EMPTY), (o_out.queue_count == 3'd0) && (o_out.head_id == 8'd0) && (o_out.head_length == 8'd0), "empty status with head data")
    // a drop only happens with the ring full
    `FPRQ_ASSERT_IMPL(a_drop_full, i_clk, i_rst_n, o_out_valid && (o_out.status == ST_DROP), o_out.queue_full, "drop while ring not full")
    // read data comes only from a head packet with payload
    `FPRQ_ASSERT_IMPL(a_read_has_payload, i_clk, i_rst_n, o_out_valid && (o_out.read_data != 8'd0), o_out.head_length > 8'd1, "read data without payload")

endmodule
